FILE: rtl/core/layer_norm_mean_stddev_macros.svh
// ----------------------------------------------------------------------------
// layer_norm_mean_stddev_macros
// Assertion macros shared by the layer normalization core.
// ----------------------------------------------------------------------------
`ifndef LAYER_NORM_MEAN_STDDEV_MACROS_SVH
`define LAYER_NORM_MEAN_STDDEV_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/ln_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_pkg
// Shared constants for the layer normalization core.
// ----------------------------------------------------------------------------
package ln_pkg;
    localparam int MaxLen = 64;
    localparam int IdxW   = $clog2(MaxLen);
    localparam int CntW   = IdxW + 1;
    localparam int SumW   = 24;
    localparam int SqW    = 38;
    // Configuration register indexes.
    localparam logic CFG_LEN = 1'b0;
    localparam logic CFG_EPS = 1'b1;
    // Unit operations.
    localparam logic [1:0] OP_SQRT = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam int DivW = 64;
    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_unit_cmd;
endpackage

FILE: rtl/core/ln_divsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ln_divsqrt
// Shared bit-serial unit: restoring 64-bit divide or 64-bit square root,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module ln_divsqrt import ln_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_unit_cmd           i_cmd,
    input  logic [DivW-1:0]     i_a,
    input  logic [DivW-1:0]     i_b,
    output logic                o_done,
    output logic [DivW-1:0]     o_q
);
    logic [DivW-1:0] r_a, r_b, r_q, r_rem, r_bit;
    logic [1:0]      r_op;
    logic            r_busy, r_done;
    logic [6:0]      r_cnt;
    logic [6:0]      w_last;
    logic [DivW:0]   w_trial;
    logic [DivW-1:0] w_shrem;
    logic [DivW-1:0] w_sq_try;

    // Divide: shift one dividend bit into the remainder and subtract.
    assign w_shrem  = {r_rem[DivW-2:0], r_a[DivW-1]};
    assign w_trial  = {1'b0, w_shrem} - {1'b0, r_b};
    assign w_sq_try = r_q + r_bit;
    assign w_last   = (r_op == OP_DIV) ? 7'(DivW-1) : 7'(DivW/2-1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_cmd.start && r_busy && (r_cnt == w_last);
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_a    <= i_a;
                r_b    <= i_b;
                r_q    <= '0;
                r_rem  <= '0;
                r_bit  <= {2'b01, {(DivW-2){1'b0}}};
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                if (r_op == OP_DIV) begin
                    r_a <= {r_a[DivW-2:0], 1'b0};
                    if (!w_trial[DivW]) begin
                        r_rem <= w_trial[DivW-1:0];
                        r_q   <= {r_q[DivW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_shrem;
                        r_q   <= {r_q[DivW-2:0], 1'b0};
                    end
                end else begin
                    // Classic digit-by-digit square root over 32 steps.
                    if (r_a >= w_sq_try) begin
                        r_a <= r_a - w_sq_try;
                        r_q <= (r_q >> 1) + r_bit;
                    end else begin
                        r_q <= r_q >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

FILE: rtl/core/layer_norm_mean_stddev.sv
`timescale 1ns / 1ps
// One sample is taken per cycle while collecting. The last sample starts a
// variance divide and a square root on the shared unit. Each element then
// takes a divide; a later element waits until the prior output beat is taken.
// Input stall holds until the last beat is offered.
// Reset (synchronous, active low) clears sums, count, sequencer and valids.
// ----------------------------------------------------------------------------
// layer_norm_mean_stddev
// Buffers a vector of Q7.8 samples and emits (x-mean)/stddev in Q5.10.
// ----------------------------------------------------------------------------
`include "layer_norm_mean_stddev_macros.svh"
module layer_norm_mean_stddev import ln_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_normalized,
    output logic               o_last_of_run
);
    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_VAR     = 3'd1;
    localparam logic [2:0] ST_SQRT    = 3'd2;
    localparam logic [2:0] ST_RD      = 3'd3;
    localparam logic [2:0] ST_DIV     = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    logic [2:0]               r_state;
    logic [6:0]               r_len;
    logic [31:0]              r_eps;
    logic signed [15:0]       r_mem [MaxLen];
    logic signed [15:0]       r_rd;
    logic signed [SumW-1:0]   r_sum;
    logic [SqW-1:0]           r_sq;
    logic [CntW-1:0]          r_cnt, r_idx;
    logic [DivW-1:0]          r_den;
    logic                     r_neg, r_start, r_dzero;
    logic                     n_start;
    logic [1:0]               r_op;
    logic [DivW-1:0]          r_a, r_b;
    logic                     r_ovalid, r_olast;
    logic signed [15:0]       r_onorm;
    logic                     w_in_acc, w_done;
    logic [CntW-1:0]          w_efflen, w_cnt1;
    logic [DivW-1:0]          w_q;
    logic signed [31:0]       w_sq;
    logic signed [SumW+8:0]   w_d;
    logic [SumW+8:0]          w_dmag;
    logic signed [63:0]       w_num;
    logic [DivW-1:0]          w_var;
    logic [DivW-1:0]          w_rq;
    t_unit_cmd                w_cmd;

    assign w_efflen = (r_len == 7'd0) ? CntW'(1) :
                      (r_len > 7'(MaxLen)) ? CntW'(MaxLen) : CntW'(r_len);
    assign w_cnt1   = r_cnt + CntW'(1);
    assign o_stall  = (r_state != ST_COLLECT);
    assign w_in_acc = i_valid && !o_stall;
    assign w_sq     = 32'(i_sample) * 32'(i_sample);
    assign w_num    = $signed(64'(r_cnt)) * $signed(64'(r_sq))
                      - 64'(r_sum) * 64'(r_sum);
    // n*x - sum for the element being emitted.
    assign w_d      = $signed((SumW+9)'(r_cnt)) * (SumW+9)'(r_rd)
                      - (SumW+9)'(r_sum);
    assign w_dmag   = w_d[SumW+8] ? (SumW+9)'(-w_d) : (SumW+9)'(w_d);
    assign w_var    = (w_q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF :
                      (w_q == 64'd0) ? 64'(r_eps) : w_q;
    // Rounded quotient: (2*mag*2^18 + den) / (2*den) == q.
    assign w_rq     = w_q;
    assign w_cmd    = '{start: r_start, op: r_op};

    always_comb begin
        n_start = 1'b0;
        case (r_state)
            ST_VAR:  n_start = 1'b1;
            ST_SQRT: n_start = w_done && (r_op == OP_DIV);
            ST_RD:   n_start = !r_ovalid && (r_den != 64'd0);
            default: n_start = 1'b0;
        endcase
    end

    ln_divsqrt u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_done (w_done),
        .o_q    (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_mem[r_cnt[IdxW-1:0]] <= i_sample;
        r_rd <= r_mem[r_idx[IdxW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_COLLECT;
            r_len    <= 7'd64;
            r_eps    <= 32'd1;
            r_sum    <= '0;
            r_sq     <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= n_start;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LEN) r_len <= i_cfg_data[6:0];
                else r_eps <= i_cfg_data;
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_COLLECT: begin
                    if (w_in_acc) begin
                        r_sum <= r_sum + SumW'(i_sample);
                        r_sq  <= r_sq + SqW'(unsigned'(w_sq));
                        r_cnt <= w_cnt1;
                        if (w_cnt1 >= w_efflen) r_state <= ST_VAR;
                    end
                end
                ST_VAR: begin
                    // Compute variance numerator; divide by n*n.
                    r_a     <= (w_num > 0) ? 64'(w_num) : 64'd0;
                    r_b     <= 64'(r_cnt) * 64'(r_cnt);
                    r_op    <= OP_DIV;
                    r_state <= ST_SQRT;
                    r_idx   <= '0;
                end
                ST_SQRT: begin
                    if (w_done) begin
                        if (r_op == OP_DIV) begin
                            r_a     <= w_var << 16;
                            r_op    <= OP_SQRT;
                        end else begin
                            r_den   <= 64'(r_cnt) * 64'(w_q[31:0]);
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    // Buffer read data valid; launch element divide.
                    if (!r_ovalid) begin
                        r_neg   <= w_d[SumW+8];
                        r_dzero <= (w_d == 0);
                        r_a     <= ({31'd0, w_dmag} << 19) + r_den;
                        r_b     <= r_den << 1;
                        r_op    <= OP_DIV;
                        r_state <= (r_den != 64'd0) ? ST_DIV : ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (w_done) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid) begin
                        if (r_den == 64'd0) begin
                            r_onorm <= r_dzero ? 16'sd0 : (r_neg ? -16'sd32768 : 16'sd32767);
                        end else if (!r_neg) begin
                            r_onorm <= (w_rq > 64'd32767) ? 16'sd32767 : 16'(w_rq);
                        end else begin
                            r_onorm <= (w_rq > 64'd32768) ? -16'sd32768 : 16'(-w_rq);
                        end
                        r_olast  <= (r_idx + CntW'(1) == r_cnt);
                        r_ovalid <= 1'b1;
                        if (r_idx + CntW'(1) == r_cnt) begin
                            r_sum   <= '0;
                            r_sq    <= '0;
                            r_cnt   <= '0;
                            r_idx   <= '0;
                            r_state <= ST_COLLECT;
                        end else begin
                            r_idx   <= r_idx + CntW'(1);
                            r_state <= ST_RD;
                        end
                    end
                end
                default: r_state <= ST_COLLECT;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_normalized  = r_onorm;
    assign o_last_of_run = r_olast;

    `LN_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != ST_COLLECT, o_stall,
                   "input taken while busy")
    `LN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
                    o_valid && $stable(o_normalized) && $stable(o_last_of_run),
                    "output beat dropped")
    `LN_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(MaxLen),
                   "count overflow")
endmodule
